### hdl/assert_macros.svh
// Assertion macros used by the RTL of the comb filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define FCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define FCF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/fcf_pkg.sv
// Package with types, constants and codes of the fractional comb filter.
`default_nettype none

package fcf_pkg;

  localparam int unsigned ADDR_BITS   = 13;
  localparam int unsigned LINE_DEPTH  = 1 << ADDR_BITS;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned POS_BITS    = ADDR_BITS + FRAC_BITS;
  localparam int unsigned DELAY_BITS  = 21;
  localparam int unsigned GAIN_BITS   = 16;
  localparam int unsigned IDX_BITS    = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;
  typedef logic [DELAY_BITS-1:0]         delay_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_word_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_word_t;

  typedef struct packed {
    sample_t xl;
    sample_t xr;
    sample_t yl;
    sample_t yr;
  } line_entry_t;

  localparam delay_t OneSampleQ8 = delay_t'(1 << FRAC_BITS);
  localparam delay_t MaxDelayQ8  = delay_t'((LINE_DEPTH - 2) << FRAC_BITS);

  localparam gain_t FbLimit    = gain_t'(32735);
  localparam gain_t FbLimitNeg = gain_t'(-32735);

  localparam sample_t SampleMax = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SampleMin = sample_t'(-(1 << (SAMPLE_BITS - 1)));

  localparam delay_t RstDelayQ8    = delay_t'(24576);
  localparam delay_t RstMaxDelayQ8 = delay_t'(2096640);
  localparam gain_t  RstDryGain    = gain_t'(8192);
  localparam gain_t  RstFfGain     = gain_t'(0);
  localparam gain_t  RstFbGain     = gain_t'(0);

  localparam logic [IDX_BITS-1:0] REG_DELAY     = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_MAX_DELAY = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_DRY_GAIN  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_FF_GAIN   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_FB_GAIN   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_MUL,
    ST_SUM
  } state_e;

endpackage

`default_nettype wire

### hdl/fcf_stream_if.sv
// Valid/ready stream interface that carries one word per handshake.
`default_nettype none

interface fcf_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/fractional_comb_filter.sv
// Top level of the stereo fractional-delay comb filter.
`default_nettype none

// The filter takes one stereo word on in_i and returns one filtered stereo word on out_o.
// A word passes through four steps inside: the step it is accepted in, when both delay-line taps
// are read from the shared line memory, a step of linear interpolation, one of gain
// multiplication, and one that sums, rounds, saturates and writes the word back at the
// write position. The next word is accepted in the cycle after that; words never overlap,
// as each makes a single read-modify-write pass through the line memory. A result that is
// not taken stalls the last step once the output register is full.
// The line memory needs no clearing pass after reset: a fill mark tracks which entries have
// been written, and unwritten entries read as zero.

`include "assert_macros.svh"

module fractional_comb_filter
  import fcf_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  fcf_stream_if.sink           in_i,
  fcf_stream_if.source         out_o,
  input  wire                  cfg_we_i,
  input  wire [IDX_BITS-1:0]   cfg_idx_i,
  input  wire [DELAY_BITS-1:0] cfg_data_i
);

  line_entry_t mem [LINE_DEPTH];

  delay_t  delay_q, max_delay_q;
  gain_t   dry_q, ff_q, fb_q;
  gain_t   fb_raw;

  state_e  state_q, state_d;
  addr_t   wpos_q;
  logic    wrapped_q;

  delay_t  mx_lim, mx_eff, d_lim, d_eff;
  logic [POS_BITS-1:0] rd_pos;
  addr_t   rd_addr_a, rd_addr_b;
  logic    accept, mem_we, out_load;
  line_entry_t wr_entry;

  line_entry_t rda_q, rdb_q;
  logic        va_q, vb_q;
  logic [FRAC_BITS-1:0] frac_q;
  sample_t     xl_q, xr_q;
  line_entry_t ea, eb;

  sample_t xdl_q, xdr_q, ydl_q, ydr_q;
  logic signed [GAIN_BITS+SAMPLE_BITS-1:0] pgl_q, pgr_q, pfl_q, pfr_q, pbl_q, pbr_q;
  sample_t yl, yr;

  logic      out_valid_q;
  out_word_t out_data_q;

  function automatic sample_t interp(sample_t a, sample_t b, logic [FRAC_BITS-1:0] f);
    logic signed [SAMPLE_BITS:0]                 diff;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0]     prod;
    logic signed [SAMPLE_BITS+FRAC_BITS+1:0]     acc;
    diff = (SAMPLE_BITS+1)'(b) - (SAMPLE_BITS+1)'(a);
    prod = diff * $signed({1'b0, f});
    acc  = {{2{a[SAMPLE_BITS-1]}}, a, {FRAC_BITS{1'b0}}} + prod
         + (SAMPLE_BITS+FRAC_BITS+2)'(1 << (FRAC_BITS - 1));
    return acc[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic sample_t combine(logic signed [GAIN_BITS+SAMPLE_BITS-1:0] pg,
                                     logic signed [GAIN_BITS+SAMPLE_BITS-1:0] pf,
                                     logic signed [GAIN_BITS+SAMPLE_BITS-1:0] pb);
    logic signed [GAIN_BITS+SAMPLE_BITS+2:0] s;
    logic signed [GAIN_BITS+SAMPLE_BITS-13:0] y;
    s = ((GAIN_BITS+SAMPLE_BITS+3)'(pg) <<< 2) + ((GAIN_BITS+SAMPLE_BITS+3)'(pf) <<< 2)
      + (GAIN_BITS+SAMPLE_BITS+3)'(pb) + (GAIN_BITS+SAMPLE_BITS+3)'(16384);
    y = s[GAIN_BITS+SAMPLE_BITS+2:15];
    if (y > (GAIN_BITS+SAMPLE_BITS-12)'(SampleMax)) begin
      return SampleMax;
    end else if (y < (GAIN_BITS+SAMPLE_BITS-12)'(SampleMin)) begin
      return SampleMin;
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers.
  always_comb begin
    fb_raw = gain_t'(cfg_data_i[GAIN_BITS-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= RstDelayQ8;
      max_delay_q <= RstMaxDelayQ8;
      dry_q       <= RstDryGain;
      ff_q        <= RstFfGain;
      fb_q        <= RstFbGain;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELAY:     delay_q     <= cfg_data_i;
        REG_MAX_DELAY: max_delay_q <= cfg_data_i;
        REG_DRY_GAIN:  dry_q       <= gain_t'(cfg_data_i[GAIN_BITS-1:0]);
        REG_FF_GAIN:   ff_q        <= gain_t'(cfg_data_i[GAIN_BITS-1:0]);
        REG_FB_GAIN: begin
          if (fb_raw > FbLimit) begin
            fb_q <= FbLimit;
          end else if (fb_raw < FbLimitNeg) begin
            fb_q <= FbLimitNeg;
          end else begin
            fb_q <= fb_raw;
          end
        end
        default: ;
      endcase
    end
  end

  // Delay clamp and tap addresses.
  always_comb begin
    mx_lim    = (max_delay_q > MaxDelayQ8) ? MaxDelayQ8 : max_delay_q;
    mx_eff    = (mx_lim < OneSampleQ8) ? OneSampleQ8 : mx_lim;
    d_lim     = (delay_q > mx_eff) ? mx_eff : delay_q;
    d_eff     = (d_lim < OneSampleQ8) ? OneSampleQ8 : d_lim;
    rd_pos    = {wpos_q, {FRAC_BITS{1'b0}}} - POS_BITS'(d_eff);
    rd_addr_a = rd_pos[POS_BITS-1:FRAC_BITS];
    rd_addr_b = rd_addr_a + addr_t'(1);
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    accept   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        accept = in_i.valid;
        if (in_i.valid) begin
          state_d = ST_INTERP;
        end
      end
      ST_INTERP: state_d = ST_MUL;
      ST_MUL:    state_d = ST_SUM;
      ST_SUM: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign mem_we     = out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q    <= '0;
      wrapped_q <= 1'b0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
    end else begin
      if (accept) begin
        va_q <= wrapped_q || (rd_addr_a < wpos_q);
        vb_q <= wrapped_q || (rd_addr_b < wpos_q);
      end
      if (mem_we) begin
        wpos_q <= wpos_q + addr_t'(1);
        if (wpos_q == addr_t'(LINE_DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
    end
  end

  // Line memory: two read ports, one write port.
  assign wr_entry = '{xl: xl_q, xr: xr_q, yl: yl, yr: yr};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wpos_q] <= wr_entry;
    end
    if (accept) begin
      rda_q <= mem[rd_addr_a];
      rdb_q <= mem[rd_addr_b];
    end
  end

  // Datapath.
  always_comb begin
    ea = va_q ? rda_q : '0;
    eb = vb_q ? rdb_q : '0;
    yl = combine(pgl_q, pfl_q, pbl_q);
    yr = combine(pgr_q, pfr_q, pbr_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xl_q   <= in_i.data.left_in;
      xr_q   <= in_i.data.right_in;
      frac_q <= rd_pos[FRAC_BITS-1:0];
    end
    if (state_q == ST_INTERP) begin
      xdl_q <= interp(ea.xl, eb.xl, frac_q);
      xdr_q <= interp(ea.xr, eb.xr, frac_q);
      ydl_q <= interp(ea.yl, eb.yl, frac_q);
      ydr_q <= interp(ea.yr, eb.yr, frac_q);
    end
    if (state_q == ST_MUL) begin
      pgl_q <= dry_q * xl_q;
      pgr_q <= dry_q * xr_q;
      pfl_q <= ff_q * xdl_q;
      pfr_q <= ff_q * xdr_q;
      pbl_q <= fb_q * ydl_q;
      pbr_q <= fb_q * ydr_q;
    end
    if (out_load) begin
      out_data_q <= '{left_out: yl, right_out: yr};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `FCF_ASSERT(a_tap_behind_write, accept |-> (rd_addr_a != wpos_q), "tap at write position")
  `FCF_ASSERT(a_pass_length, accept |=> ##2 (state_q == ST_SUM), "pass length wrong")
  `FCF_ASSERT(a_wpos_step, mem_we |=> (wpos_q == $past(wpos_q) + addr_t'(1)), "bad advance")
  `FCF_ASSERT(a_wrap_sticky, wrapped_q |=> wrapped_q, "fill mark cleared")

endmodule

`default_nettype wire

### test/tb_fractional_comb_filter.sv
// Self-checking testbench for the stereo fractional-delay comb filter.
`timescale 1ns / 1ps

module tb_fractional_comb_filter;
  import fcf_pkg::*;

  class stereo_comb;
    sample_t in_l[LINE_DEPTH];
    sample_t in_r[LINE_DEPTH];
    sample_t out_l[LINE_DEPTH];
    sample_t out_r[LINE_DEPTH];
    addr_t wr_ptr;
    delay_t delay_q8;
    delay_t max_q8;
    gain_t dry;
    gain_t ff;
    gain_t fb;
    out_word_t expected_pairs[$];
    int errors;

    function new();
      for (int i = 0; i < LINE_DEPTH; i++) begin
        in_l[i] = '0;
        in_r[i] = '0;
        out_l[i] = '0;
        out_r[i] = '0;
      end
      wr_ptr = '0;
      delay_q8 = RstDelayQ8;
      max_q8 = RstMaxDelayQ8;
      dry = RstDryGain;
      ff = RstFfGain;
      fb = RstFbGain;
      errors = 0;
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, delay_t data);
      gain_t g;
      g = gain_t'(data[GAIN_BITS-1:0]);
      case (idx)
        REG_DELAY: delay_q8 = data;
        REG_MAX_DELAY: max_q8 = data;
        REG_DRY_GAIN: dry = g;
        REG_FF_GAIN: ff = g;
        REG_FB_GAIN: begin
          if (g > FbLimit) fb = FbLimit;
          else if (g < FbLimitNeg) fb = FbLimitNeg;
          else fb = g;
        end
        default: ;
      endcase
    endfunction

    function longint tap(sample_t a, sample_t b, int f);
      return (longint'(a) * (256 - f) + longint'(b) * f + 128) >>> 8;
    endfunction

    function sample_t filter_channel(sample_t x, sample_t xa, sample_t xb,
                                     sample_t ya, sample_t yb, int f);
      longint s;
      longint y;
      s = 4 * longint'(dry) * longint'(x) + 4 * longint'(ff) * tap(xa, xb, f)
          + longint'(fb) * tap(ya, yb, f);
      y = (s + 16384) >>> 15;
      if (y > longint'(SampleMax)) y = longint'(SampleMax);
      if (y < longint'(SampleMin)) y = longint'(SampleMin);
      return sample_t'(y);
    endfunction

    function void take_pair(in_word_t w);
      longint mx;
      longint d;
      longint span;
      longint pos;
      int ia;
      int ib;
      int f;
      out_word_t r;
      mx = longint'(max_q8);
      if (mx > longint'(MaxDelayQ8)) mx = longint'(MaxDelayQ8);
      if (mx < longint'(OneSampleQ8)) mx = longint'(OneSampleQ8);
      d = longint'(delay_q8);
      if (d > mx) d = mx;
      if (d < longint'(OneSampleQ8)) d = longint'(OneSampleQ8);
      span = longint'(LINE_DEPTH) * 256;
      pos = (longint'(wr_ptr) * 256 + span - d) % span;
      ia = int'(pos >>> 8);
      ib = (ia + 1) % LINE_DEPTH;
      f = int'(pos & 255);
      r.left_out = filter_channel(w.left_in, in_l[ia], in_l[ib], out_l[ia], out_l[ib], f);
      r.right_out = filter_channel(w.right_in, in_r[ia], in_r[ib], out_r[ia], out_r[ib], f);
      in_l[wr_ptr] = w.left_in;
      in_r[wr_ptr] = w.right_in;
      out_l[wr_ptr] = r.left_out;
      out_r[wr_ptr] = r.right_out;
      wr_ptr = wr_ptr + 1'b1;
      expected_pairs.push_back(r);
    endfunction

    function void compare_pair(out_word_t got);
      out_word_t want;
      if (expected_pairs.size() == 0) begin
        $error("unexpected word: left_out %0d, right_out %0d", got.left_out, got.right_out);
        errors++;
        return;
      end
      want = expected_pairs.pop_front();
      if (got.left_out !== want.left_out) begin
        $error("left_out: expected %0d, actual %0d", want.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== want.right_out) begin
        $error("right_out: expected %0d, actual %0d", want.right_out, got.right_out);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [IDX_BITS-1:0] cfg_idx_i;
  logic [DELAY_BITS-1:0] cfg_data_i;

  bit tx_gap_on;
  bit rx_stall_on;
  int hold_req;

  stereo_comb model = new();

  fcf_stream_if #(.word_t(in_word_t)) in_if ();
  fcf_stream_if #(.word_t(out_word_t)) out_if ();

  fractional_comb_filter u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) model.take_pair(in_if.data);
    if (rst_ni && out_if.valid && out_if.ready) model.compare_pair(out_if.data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t stereo(sample_t l, sample_t r);
    in_word_t w;
    w.left_in = l;
    w.right_in = r;
    return w;
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return sample_t'($urandom);
    if (r < 8) return sample_t'($urandom_range(0, 255)) - sample_t'(128);
    case ($urandom_range(0, 3))
      0: return SampleMax;
      1: return SampleMin;
      2: return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  function automatic delay_t rand_gain_data();
    gain_t g;
    if ($urandom_range(0, 99) < 30) begin
      case ($urandom_range(0, 5))
        0: g = gain_t'(32767);
        1: g = gain_t'(-32768);
        2: g = gain_t'(0);
        3: g = FbLimit;
        4: g = FbLimitNeg;
        default: g = gain_t'(8192);
      endcase
    end else begin
      g = gain_t'($urandom);
    end
    return {5'($urandom), g};
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_stall_on) stall_left = pick_gap();
      end
    end
  end

  task automatic push_word(in_word_t w);
    int gap;
    gap = tx_gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [IDX_BITS-1:0] idx, delay_t data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    model.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic retune();
    delay_t v;
    int r;
    if ($urandom_range(0, 99) < 70) begin
      r = $urandom_range(0, 99);
      if (r < 60) v = delay_t'($urandom_range(256, 48 * 256));
      else if (r < 75) begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = delay_t'(255);
          2: v = OneSampleQ8;
          default: v = '1;
        endcase
      end else v = delay_t'($urandom);
      set_reg(REG_DELAY, v);
    end
    if ($urandom_range(0, 99) < 70) begin
      r = $urandom_range(0, 99);
      if (r < 50) v = MaxDelayQ8;
      else if (r < 65) v = delay_t'($urandom_range(256, 64 * 256));
      else if (r < 80) begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = OneSampleQ8;
          2: v = MaxDelayQ8;
          default: v = '1;
        endcase
      end else v = delay_t'($urandom);
      set_reg(REG_MAX_DELAY, v);
    end
    if ($urandom_range(0, 99) < 70) set_reg(REG_DRY_GAIN, rand_gain_data());
    if ($urandom_range(0, 99) < 70) set_reg(REG_FF_GAIN, rand_gain_data());
    if ($urandom_range(0, 99) < 70) set_reg(REG_FB_GAIN, rand_gain_data());
    if ($urandom_range(0, 99) < 20) begin
      set_reg(IDX_BITS'($urandom_range(REG_FB_GAIN + 1, (1 << IDX_BITS) - 1)),
              delay_t'($urandom));
    end
  endtask

  initial begin
    #2_000_000;
    $display("fractional_comb_filter: mismatch");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_DELAY;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    tx_gap_on = 1'b0;
    rx_stall_on = 1'b0;
    hold_req = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_word(stereo(SampleMax, SampleMin));
    push_word(stereo(SampleMin, SampleMax));
    push_word(stereo(sample_t'(0), sample_t'(-1)));
    push_word(stereo(sample_t'(24'h555555), sample_t'(24'hAAAAAA)));
    push_word(stereo(sample_t'(1), sample_t'(-1)));
    settle();

    // Delay below one sample, feedback above its limit, writes to unused indexes.
    set_reg(REG_DELAY, '0);
    set_reg(REG_DRY_GAIN, delay_t'(gain_t'(32767)));
    set_reg(REG_FF_GAIN, delay_t'(gain_t'(-32768)));
    set_reg(REG_FB_GAIN, delay_t'(gain_t'(32767)));
    set_reg(IDX_BITS'(REG_FB_GAIN + 1), delay_t'(123));
    set_reg('1, '1);
    push_word(stereo(SampleMax, SampleMin));
    push_word(stereo(SampleMax, SampleMin));
    push_word(stereo(SampleMin, SampleMax));
    push_word(stereo(sample_t'(0), sample_t'(0)));
    push_word(stereo(sample_t'(-1), sample_t'(1)));
    push_word(stereo(SampleMax, SampleMax));
    settle();

    // Maximum below one sample, delay at its top, feedback below its limit.
    set_reg(REG_MAX_DELAY, '0);
    set_reg(REG_DELAY, '1);
    set_reg(REG_DRY_GAIN, delay_t'(gain_t'(-32768)));
    set_reg(REG_FF_GAIN, delay_t'(gain_t'(32767)));
    set_reg(REG_FB_GAIN, delay_t'(gain_t'(-32768)));
    push_word(stereo(SampleMin, SampleMax));
    push_word(stereo(SampleMax, SampleMin));
    push_word(stereo(SampleMin, SampleMin));
    push_word(stereo(sample_t'(12345), sample_t'(-54321)));
    push_word(stereo(sample_t'(0), sample_t'(0)));
    settle();

    // Maximum above the line length, then a fractional delay.
    set_reg(REG_MAX_DELAY, '1);
    set_reg(REG_DRY_GAIN, delay_t'(gain_t'(8192)));
    set_reg(REG_FF_GAIN, delay_t'(gain_t'(8192)));
    set_reg(REG_FB_GAIN, delay_t'(gain_t'(16384)));
    push_word(stereo(sample_t'(1000000), sample_t'(-1000000)));
    push_word(stereo(SampleMax, SampleMin));
    push_word(stereo(sample_t'(-3), sample_t'(7)));
    settle();
    set_reg(REG_DELAY, delay_t'(5 * 256 + 77));
    set_reg(REG_FF_GAIN, delay_t'(gain_t'(-8192)));
    set_reg(REG_FB_GAIN, delay_t'(gain_t'(32000)));
    for (int i = 0; i < 5; i++) push_word(stereo(rand_sample(), rand_sample()));
    settle();

    for (int phase = 0; phase < 12; phase++) begin
      retune();
      tx_gap_on = $urandom_range(0, 3) != 0;
      rx_stall_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 110; i++) begin
        if (phase == 2 && i == 20) hold_req = 300;
        if (phase == 5 && i == 50) settle();
        push_word(stereo(rand_sample(), rand_sample()));
      end
      settle();
    end

    if (model.errors == 0 && model.pending() == 0) begin
      $display("fractional_comb_filter: match");
    end else begin
      $display("fractional_comb_filter: mismatch");
    end
    $finish;
  end

endmodule

### fractional_comb_filter.f
+incdir+hdl
hdl/fcf_pkg.sv
hdl/fcf_stream_if.sv
hdl/fractional_comb_filter.sv
test/tb_fractional_comb_filter.sv
